// ===== sv/ucmp_pkg.sv =====
// Shared types and constants for the UART command mode parser.
// No dependencies; every other file imports this package.
`default_nettype none

package ucmp_pkg;

	localparam int IDX_W = 5;

	// Request kinds.
	localparam logic OP_RX = 1'b0;
	localparam logic OP_SW = 1'b1;

	// Modes with a collecting role.
	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_CMD    = 3'd1;
	localparam logic [2:0] MODE_SINGLE = 3'd3;
	localparam logic [2:0] MODE_ANGLE  = 3'd4;
	localparam logic [2:0] MODE_FILE   = 3'd5;
	localparam logic [2:0] MODE_DIGIT  = 3'd6;

	// Characters.
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_SEVEN = 8'h37;
	localparam logic [7:0] CHAR_NL    = 8'h0A;
	localparam logic [7:0] HEX_ADJ    = 8'd39;
	localparam logic [7:0] DEC_MAX    = 8'd9;

	typedef enum logic [2:0] {
		TGT_NONE  = 3'd0,
		TGT_CMD   = 3'd1,
		TGT_ANGLE = 3'd2,
		TGT_DIGIT = 3'd3,
		TGT_COUNT = 3'd4
	} target_t;

	typedef struct packed {
		logic       op;
		logic [7:0] rx_byte;
		logic [2:0] new_mode;
		logic       new_first_flag;
	} item_t;

	typedef struct packed {
		logic [2:0]       mode;
		logic             first_flag;
		logic [IDX_W-1:0] index;
	} state_t;

	typedef struct packed {
		logic [2:0]       mode_now;
		logic             wake;
		logic             send_ack;
		target_t          store_target;
		logic [IDX_W-1:0] store_index;
		logic [7:0]       store_value;
		logic             overflow;
	} result_t;

endpackage

`default_nettype wire

// ===== sv/uart_command_mode_parser.sv =====
// Top level of the UART command mode parser: request register, parser state,
// result register. Depends on ucmp_pkg and ucmp_step.
//
//   channel   handshake             payload
//   request   req_valid/req_stall   op, rx_byte, new_mode, new_first_flag
//   result    res_valid/res_stall   mode_now, wake, send_ack, store_target,
//                                   store_index, store_value, overflow
//
// Every request yields one result, valid once it moves from the request
// register into the result register; it is taken while res_stall is low.
// One request is taken per cycle while req_stall is low; the parser state
// updates as a request moves from request register to result register.
// Reset clears mode, first-byte flag, buffer index and both valid flags.
// A stalled result holds; one more request waits in the request register
// before req_stall rises.
`default_nettype none

module uart_command_mode_parser #(
	parameter int CMD_DEPTH   = 8,
	parameter int ANGLE_DEPTH = 4,
	parameter int DIGIT_DEPTH = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   req_valid,
	output logic                        req_stall,
	input  wire logic                   op,
	input  wire logic [7:0]             rx_byte,
	input  wire logic [2:0]             new_mode,
	input  wire logic                   new_first_flag,
	output logic                        res_valid,
	input  wire logic                   res_stall,
	output logic [2:0]                  mode_now,
	output logic                        wake,
	output logic                        send_ack,
	output logic [2:0]                  store_target,
	output logic [ucmp_pkg::IDX_W-1:0]  store_index,
	output logic [7:0]                  store_value,
	output logic                        overflow
);
	import ucmp_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t res_s2;
	state_t  st_q;
	state_t  st_nxt;
	result_t res_nxt;
	logic    adv;

	ucmp_step #(
		.CMD_DEPTH   (CMD_DEPTH),
		.ANGLE_DEPTH (ANGLE_DEPTH),
		.DIGIT_DEPTH (DIGIT_DEPTH)
	) u_step (
		.item (item_s1),
		.cur  (st_q),
		.nxt  (st_nxt),
		.res  (res_nxt)
	);

	assign adv       = valid_s1 && (!valid_s2 || !res_stall);
	assign req_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			item_s1.op             <= op;
			item_s1.rx_byte        <= rx_byte;
			item_s1.new_mode       <= new_mode;
			item_s1.new_first_flag <= new_first_flag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			st_q     <= '0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
			st_q     <= st_nxt;
		end else if (!res_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_nxt;
		end
	end

	assign res_valid    = valid_s2;
	assign mode_now     = res_s2.mode_now;
	assign wake         = res_s2.wake;
	assign send_ack     = res_s2.send_ack;
	assign store_target = res_s2.store_target;
	assign store_index  = res_s2.store_index;
	assign store_value  = res_s2.store_value;
	assign overflow     = res_s2.overflow;

`ifndef ASSERT_OFF
	a_ovf_no_store: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && overflow |-> store_target == TGT_NONE)
		else $error("overflow reported together with a store");

	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && store_target == TGT_NONE |-> store_value == 8'd0 && store_index == '0)
		else $error("store without target carries data");

	a_ack_wakes: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && send_ack |-> wake)
		else $error("ack raised without wake");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1 && valid_s2 && res_stall)
		else $error("request stalled while the pipeline can move");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(st_q))
		else $error("parser state changed without a request");
`endif

endmodule

`default_nettype wire

// ===== sv/ucmp_step.sv =====
// Combinational step of the parser: next state and result for one request.
// Depends on ucmp_pkg.
`default_nettype none

module ucmp_step #(
	parameter int CMD_DEPTH   = 8,
	parameter int ANGLE_DEPTH = 4,
	parameter int DIGIT_DEPTH = 32
) (
	input  ucmp_pkg::item_t   item,
	input  ucmp_pkg::state_t  cur,
	output ucmp_pkg::state_t  nxt,
	output ucmp_pkg::result_t res
);
	import ucmp_pkg::*;

	localparam logic [IDX_W:0] CMD_LIM   = (IDX_W+1)'(CMD_DEPTH);
	localparam logic [IDX_W:0] ANGLE_LIM = (IDX_W+1)'(ANGLE_DEPTH);
	localparam logic [IDX_W:0] DIGIT_LIM = (IDX_W+1)'(DIGIT_DEPTH);

	logic [7:0]       b;
	logic [7:0]       b_off;
	logic [7:0]       hex_val;
	logic             is_nl;
	logic             do_put;
	logic             nl_clear;
	target_t          put_tgt;
	logic [IDX_W:0]   put_lim;
	logic [7:0]       put_val;
	logic [2:0]       digit;

	assign b     = item.rx_byte;
	assign b_off = b - CHAR_ZERO;
	assign is_nl = (b == CHAR_NL);
	assign digit = b[2:0];

	// Hex letters: a value that is positive as a signed byte and above nine is
	// pulled down by a further 39.
	assign hex_val = (!b_off[7] && (b_off > DEC_MAX)) ? (b_off - HEX_ADJ) : b_off;

	always_comb begin
		nxt      = cur;
		res      = '0;
		do_put   = 1'b0;
		nl_clear = 1'b0;
		put_tgt  = TGT_NONE;
		put_lim  = '0;
		put_val  = '0;

		priority if (item.op == OP_SW) begin
			nxt.mode       = item.new_mode;
			nxt.first_flag = item.new_first_flag;
			nxt.index      = '0;
		end else if (cur.mode == MODE_CMD) begin
			do_put   = 1'b1;
			put_tgt  = TGT_CMD;
			put_lim  = CMD_LIM;
			put_val  = b;
			nl_clear = is_nl;
		end else if (cur.mode == MODE_SINGLE) begin
			res.store_target = TGT_CMD;
			res.store_value  = b;
			res.wake         = 1'b1;
		end else if (cur.mode == MODE_ANGLE && cur.first_flag) begin
			do_put   = 1'b1;
			put_tgt  = TGT_ANGLE;
			put_lim  = ANGLE_LIM;
			put_val  = b;
			nl_clear = is_nl;
			if (is_nl) begin
				nxt.first_flag = 1'b0;
			end
		end else if (cur.mode == MODE_FILE) begin
			priority if (!cur.first_flag) begin
				res.store_target = TGT_COUNT;
				res.store_value  = b_off;
				res.wake         = 1'b1;
				nxt.first_flag   = 1'b1;
				nxt.index        = '0;
			end else if (is_nl) begin
				res.send_ack = 1'b1;
				res.wake     = 1'b1;
			end else begin
				do_put  = 1'b1;
				put_tgt = TGT_DIGIT;
				put_lim = DIGIT_LIM;
				put_val = hex_val;
			end
		end else if (cur.mode == MODE_DIGIT && cur.first_flag) begin
			res.store_target = TGT_CMD;
			res.store_value  = b_off;
			res.wake         = 1'b1;
			nxt.first_flag   = 1'b0;
		end else begin
			if (b >= CHAR_ZERO && b <= CHAR_SEVEN) begin
				nxt.mode     = digit;
				res.wake     = (digit != MODE_IDLE);
				res.send_ack = (digit == MODE_FILE) || (digit == MODE_DIGIT);
				if (digit == MODE_CMD) begin
					nxt.index = '0;
				end
				if (digit == MODE_ANGLE || digit == MODE_DIGIT) begin
					nxt.first_flag = 1'b1;
				end
			end
		end

		// Indexed buffer write; a full buffer drops the byte and keeps the index.
		if (do_put) begin
			if ({1'b0, cur.index} < put_lim) begin
				res.store_target = put_tgt;
				res.store_index  = cur.index;
				res.store_value  = put_val;
				nxt.index        = cur.index + {{(IDX_W-1){1'b0}}, 1'b1};
			end else begin
				res.overflow = 1'b1;
			end
		end

		// A newline ends a line even when its own byte was dropped.
		if (nl_clear) begin
			nxt.index = '0;
			res.wake  = 1'b1;
		end

		res.mode_now = nxt.mode;
	end

endmodule

`default_nettype wire
